FILE: src/sss_pkg.sv
// types, constants and scan functions shared by the sql statement splitter
package sss_pkg;

  localparam int unsigned CntW         = 17;
  localparam int unsigned MaxTextLimit = 65536;
  localparam int unsigned ItemDepth    = 4;
  localparam int unsigned ResultDepth  = 4;

  localparam logic [CntW-1:0] LimitRst = 17'h10000;

  // result kinds
  localparam logic [1:0] KindSeg = 2'd0;
  localparam logic [1:0] KindEnd = 2'd1;
  localparam logic [1:0] KindErr = 2'd2;

  // byte codes
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChVt    = 8'h0b;

  typedef enum logic [3:0] {
    ClsOther,
    ClsQuote,
    ClsDash,
    ClsSlash,
    ClsStar,
    ClsSemi,
    ClsLf,
    ClsCr,
    ClsSpace
  } cls_e;

  typedef enum logic [3:0] {
    ModeNormal = 4'b0001,
    ModeString = 4'b0010,
    ModeLine   = 4'b0100,
    ModeBlock  = 4'b1000
  } mode_e;

  typedef struct packed {
    cls_e cls;
    logic eot;
  } item_t;

  typedef struct packed {
    mode_e           mode;
    logic            content;
    logic [CntW-1:0] line;
    logic [CntW-1:0] col;
    logic [CntW-1:0] off;
    logic [CntW-1:0] st_off;
    logic [CntW-1:0] st_line;
    logic [CntW-1:0] st_col;
  } scan_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CntW-1:0] seg_begin;
    logic [CntW-1:0] seg_end;
    logic [CntW-1:0] begin_line;
    logic [CntW-1:0] begin_column;
    logic [CntW-1:0] end_line;
    logic [CntW-1:0] end_column;
    logic            unterminated;
    logic            last;
  } result_t;

  typedef struct packed {
    scan_t   st;
    logic    paired;
    logic    seg;
    result_t res;
  } scan_out_t;

  localparam scan_t ScanRst = '{
    mode: ModeNormal, content: 1'b0,
    line: 17'd1, col: 17'd1, off: 17'd0,
    st_off: 17'd0, st_line: 17'd1, st_col: 17'd1
  };

  localparam result_t ResErr = '{
    kind: KindErr, seg_begin: 17'd0, seg_end: 17'd0,
    begin_line: 17'd1, begin_column: 17'd1, end_line: 17'd1, end_column: 17'd1,
    unterminated: 1'b0, last: 1'b1
  };

  localparam result_t ResEnd = '{
    kind: KindEnd, seg_begin: 17'd0, seg_end: 17'd0,
    begin_line: 17'd0, begin_column: 17'd0, end_line: 17'd0, end_column: 17'd0,
    unterminated: 1'b0, last: 1'b1
  };

  function automatic cls_e classify_f(logic [7:0] b);
    cls_e c;
    unique case (b) inside
      ChQuote: c = ClsQuote;
      ChDash:  c = ClsDash;
      ChSlash: c = ClsSlash;
      ChStar:  c = ClsStar;
      ChSemi:  c = ClsSemi;
      ChLf:    c = ClsLf;
      ChCr:    c = ClsCr;
      ChTab, ChSpace, ChFf, ChVt: c = ClsSpace;
      default: c = ClsOther;
    endcase
    return c;
  endfunction

  // one byte of position advance
  function automatic scan_t adv_f(scan_t s, cls_e c);
    scan_t t;
    t = s;
    if (c == ClsLf) begin
      t.line = s.line + 17'd1;
      t.col  = 17'd1;
    end else if (c != ClsCr) begin
      t.col = s.col + 17'd1;
    end
    t.off = s.off + 17'd1;
    return t;
  endfunction

  // two-byte opener, closer or doubled quote, never a line break
  function automatic scan_t adv2_f(scan_t s);
    scan_t t;
    t = s;
    t.col = s.col + 17'd2;
    t.off = s.off + 17'd2;
    return t;
  endfunction

  function automatic result_t seg_f(scan_t t, logic unterm);
    result_t r;
    r.kind         = KindSeg;
    r.seg_begin    = t.st_off;
    r.seg_end      = t.off;
    r.begin_line   = t.st_line;
    r.begin_column = t.st_col;
    r.end_line     = t.line;
    r.end_column   = t.col;
    r.unterminated = unterm;
    r.last         = 1'b0;
    return r;
  endfunction

  // scan one byte with optional lookahead
  function automatic scan_out_t scan_f(scan_t s, cls_e c, cls_e n, logic nv);
    scan_out_t o;
    scan_t     t;
    o.st     = s;
    o.paired = 1'b0;
    o.seg    = 1'b0;
    o.res    = '0;
    unique case (s.mode)
      ModeNormal: begin
        if (c == ClsQuote) begin
          o.st         = adv_f(s, c);
          o.st.content = 1'b1;
          o.st.mode    = ModeString;
        end else if (c == ClsDash && nv && n == ClsDash) begin
          o.st      = adv2_f(s);
          o.st.mode = ModeLine;
          o.paired  = 1'b1;
        end else if (c == ClsSlash && nv && n == ClsStar) begin
          o.st      = adv2_f(s);
          o.st.mode = ModeBlock;
          o.paired  = 1'b1;
        end else if (c == ClsSemi) begin
          t         = adv_f(s, c);
          o.seg     = s.content;
          o.res     = seg_f(t, 1'b0);
          t.st_off  = t.off;
          t.st_line = t.line;
          t.st_col  = t.col;
          t.content = 1'b0;
          o.st      = t;
        end else begin
          o.st = adv_f(s, c);
          if (!(c == ClsLf || c == ClsCr || c == ClsSpace)) begin
            o.st.content = 1'b1;
          end
        end
      end
      ModeString: begin
        if (c == ClsQuote && nv && n == ClsQuote) begin
          o.st     = adv2_f(s);
          o.paired = 1'b1;
        end else begin
          o.st = adv_f(s, c);
          if (c == ClsQuote) begin
            o.st.mode = ModeNormal;
          end
        end
      end
      ModeLine: begin
        o.st = adv_f(s, c);
        if (c == ClsLf) begin
          o.st.mode = ModeNormal;
        end
      end
      ModeBlock: begin
        if (c == ClsStar && nv && n == ClsSlash) begin
          o.st      = adv2_f(s);
          o.st.mode = ModeNormal;
          o.paired  = 1'b1;
        end else begin
          o.st = adv_f(s, c);
        end
      end
      default: begin
        o.st = adv_f(s, c);
      end
    endcase
    return o;
  endfunction

endpackage

FILE: src/sss_fifo.sv
// small flop-based queue used between the splitter stages
module sss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntQW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntQW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/sss_front.sv
// front end: takes text bytes and classifies them for the scanner
module sss_front import sss_pkg::*; (
  input  logic       push_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output item_t      q_item_o,
  output logic       full_o
);

  assign full_o         = q_full_i;
  assign q_push_o       = push_i && !q_full_i;
  assign q_item_o.cls   = classify_f(text_byte_i);
  assign q_item_o.eot   = end_of_text_i;

endmodule

FILE: src/sss_scan.sv
// back end: mode tracking, position counters, segment and length checks
module sss_scan import sss_pkg::*; #(
  parameter int unsigned MAX_TEXT_LIMIT = MaxTextLimit
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  item_t           in_item_i,
  output logic            in_pop_o,
  input  logic            out_full_i,
  output logic            out_push_o,
  output result_t         out_result_o,
  input  logic            cfg_valid_i,
  input  logic [CntW-1:0] cfg_data_i
);

  localparam int unsigned LimW = $clog2(MAX_TEXT_LIMIT + 1);
  localparam int unsigned CmpW = (LimW > CntW + 1) ? LimW : CntW + 1;

  scan_t           scan_q;
  cls_e            held_q;
  logic            pend_q;
  logic            ovf_q;
  logic            phase_q, phase_d;
  logic [CntW-1:0] limit_q;

  logic [CmpW-1:0] cfg_lim, max_lim, lim_eff, bytes_seen;
  logic            ovf, use2, unterm, v1, v2, v3, go;
  scan_out_t       sa, sb;
  scan_t           s_fin;
  result_t         fin_res, r0, r1;
  logic [1:0]      n_seg, cnt;

  assign cfg_lim    = CmpW'(limit_q);
  assign max_lim    = CmpW'(MAX_TEXT_LIMIT);
  assign lim_eff    = (cfg_lim > max_lim) ? max_lim : cfg_lim;
  assign bytes_seen = CmpW'(scan_q.off) + CmpW'(pend_q) + CmpW'(1);

  always_comb begin
    ovf = ovf_q || (bytes_seen > lim_eff);
    sa  = scan_f(scan_q, held_q, in_item_i.cls, 1'b1);
    if (!pend_q) begin
      sa.st     = scan_q;
      sa.paired = 1'b0;
      sa.seg    = 1'b0;
    end
    use2    = in_item_i.eot && !sa.paired;
    sb      = scan_f(sa.st, in_item_i.cls, ClsOther, 1'b0);
    s_fin   = use2 ? sb.st : sa.st;
    unterm  = (s_fin.mode == ModeString) || (s_fin.mode == ModeBlock);
    v1      = !ovf && sa.seg;
    v2      = !ovf && use2 && sb.seg;
    v3      = !ovf && in_item_i.eot && (s_fin.content || unterm);
    fin_res = seg_f(s_fin, unterm);
    r0      = v1 ? sa.res : (v2 ? sb.res : fin_res);
    r1      = (v1 && v2) ? sb.res : fin_res;
    n_seg   = 2'(v1) + 2'(v2) + 2'(v3);
    cnt     = (n_seg > 2'd2) ? 2'd2 : n_seg;
    if (in_item_i.eot) begin
      if (ovf) begin
        r0  = ResErr;
        cnt = 2'd1;
      end else if (cnt == 2'd0) begin
        r0  = ResEnd;
        cnt = 2'd1;
      end else if (cnt == 2'd1) begin
        r0.last = 1'b1;
      end else begin
        r1.last = 1'b1;
      end
    end
  end

  // an item with two results holds the queue head until its second result is pushed
  assign go           = in_valid_i && !out_full_i;
  assign out_push_o   = go && (cnt != 2'd0);
  assign out_result_o = phase_q ? r1 : r0;
  assign in_pop_o     = go && !(cnt == 2'd2 && !phase_q);

  always_comb begin
    phase_d = phase_q;
    if (go) begin
      phase_d = (cnt == 2'd2) && !phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= ScanRst;
      held_q  <= ClsOther;
      pend_q  <= 1'b0;
      ovf_q   <= 1'b0;
      phase_q <= 1'b0;
      limit_q <= LimitRst;
    end else begin
      phase_q <= phase_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (in_pop_o) begin
        if (in_item_i.eot) begin
          scan_q <= ScanRst;
          pend_q <= 1'b0;
          ovf_q  <= 1'b0;
        end else if (ovf) begin
          ovf_q <= 1'b1;
        end else begin
          scan_q <= sa.st;
          held_q <= in_item_i.cls;
          pend_q <= !sa.paired;
        end
      end
    end
  end

endmodule

FILE: src/sql_statement_splitter_top.sv
// top level of the sql statement splitter
// throughput: one item per cycle while the result queue is not full; an item with two
// results holds the scanner until the single write port of the result queue has taken both
// reset: asynchronous, active low; queues empty, scanner at start of text,
// length limit at 65536
module sql_statement_splitter_top import sss_pkg::*; #(
  parameter int unsigned MAX_TEXT_LIMIT = MaxTextLimit,
  parameter int unsigned ITEM_DEPTH     = ItemDepth,
  parameter int unsigned RESULT_DEPTH   = ResultDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_text_i,
  output logic            empty,
  input  logic            pop,
  output logic [1:0]      kind_o,
  output logic [CntW-1:0] seg_begin_o,
  output logic [CntW-1:0] seg_end_o,
  output logic [CntW-1:0] begin_line_o,
  output logic [CntW-1:0] begin_column_o,
  output logic [CntW-1:0] end_line_o,
  output logic [CntW-1:0] end_column_o,
  output logic            unterminated_o,
  output logic            last_of_text_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] max_text_bytes_i
);

  logic    iq_push, iq_full, iq_empty, iq_pop;
  item_t   iq_wdata, iq_rdata;
  logic    rq_push, rq_full;
  result_t rq_wdata, rq_rdata;

  assign cfg_ready_o = 1'b1;

  sss_front u_front (
    .push_i        (push),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (iq_full),
    .q_push_o      (iq_push),
    .q_item_o      (iq_wdata),
    .full_o        (full)
  );

  sss_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (iq_push),
    .wdata_i (iq_wdata),
    .full_o  (iq_full),
    .pop_i   (iq_pop),
    .rdata_o (iq_rdata),
    .empty_o (iq_empty)
  );

  sss_scan #(
    .MAX_TEXT_LIMIT (MAX_TEXT_LIMIT)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!iq_empty),
    .in_item_i    (iq_rdata),
    .in_pop_o     (iq_pop),
    .out_full_i   (rq_full),
    .out_push_o   (rq_push),
    .out_result_o (rq_wdata),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (max_text_bytes_i)
  );

  sss_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (rq_rdata),
    .empty_o (empty)
  );

  assign kind_o         = rq_rdata.kind;
  assign seg_begin_o    = rq_rdata.seg_begin;
  assign seg_end_o      = rq_rdata.seg_end;
  assign begin_line_o   = rq_rdata.begin_line;
  assign begin_column_o = rq_rdata.begin_column;
  assign end_line_o     = rq_rdata.end_line;
  assign end_column_o   = rq_rdata.end_column;
  assign unterminated_o = rq_rdata.unterminated;
  assign last_of_text_o = rq_rdata.last;

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KindSeg || kind_o == KindEnd || kind_o == KindErr))
    else $error("undefined result kind");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KindErr) |-> (last_of_text_o && !unterminated_o))
    else $error("length error result not final");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KindEnd) |-> (last_of_text_o && seg_end_o == '0))
    else $error("end of text result malformed");

  a_unterm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && unterminated_o) |-> (last_of_text_o && kind_o == KindSeg))
    else $error("unterminated flag on a non-final segment");
`endif

endmodule

FILE: bench/sss_result_checker.sv
// result checker for the sql statement splitter: predicts segments and compares results
module sss_result_checker import sss_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_text_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CntW-1:0] cfg_data_i,
  input  logic            empty_i,
  input  logic            pop_i,
  input  logic [1:0]      kind_i,
  input  logic [CntW-1:0] seg_begin_i,
  input  logic [CntW-1:0] seg_end_i,
  input  logic [CntW-1:0] begin_line_i,
  input  logic [CntW-1:0] begin_column_i,
  input  logic [CntW-1:0] end_line_i,
  input  logic [CntW-1:0] end_column_i,
  input  logic            unterminated_i,
  input  logic            last_of_text_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              items_o,
  output int              segs_o,
  output int              unterm_o,
  output int              ends_o,
  output int              errors_o
);

  mode_e           mode_q;
  logic [7:0]      held_q;
  bit              held_v;
  bit              held_used;
  bit              content_q;
  bit              over_q;
  logic [CntW-1:0] limit_q;
  logic [CntW-1:0] line_q;
  logic [CntW-1:0] col_q;
  logic [CntW-1:0] off_q;
  logic [CntW-1:0] st_off_q;
  logic [CntW-1:0] st_line_q;
  logic [CntW-1:0] st_col_q;
  int              step_cnt;
  result_t         segment_q [$];

  task automatic clear_text();
    mode_q    = ModeNormal;
    held_q    = 8'h00;
    held_v    = 1'b0;
    held_used = 1'b0;
    content_q = 1'b0;
    over_q    = 1'b0;
    line_q    = 17'd1;
    col_q     = 17'd1;
    off_q     = 17'd0;
    st_off_q  = 17'd0;
    st_line_q = 17'd1;
    st_col_q  = 17'd1;
  endtask

  task automatic add_expect(input result_t r);
    segment_q.insert(segment_q.size(), r);
  endtask

  task automatic step_pos(input logic [7:0] c);
    if (c == ChLf) begin
      line_q = line_q + 17'd1;
      col_q  = 17'd1;
    end else if (c != ChCr) begin
      col_q = col_q + 17'd1;
    end
    off_q = off_q + 17'd1;
  endtask

  task automatic emit_seg(input bit unterm);
    result_t r;
    if (step_cnt < 2) begin
      r.kind         = KindSeg;
      r.seg_begin    = st_off_q;
      r.seg_end      = off_q;
      r.begin_line   = st_line_q;
      r.begin_column = st_col_q;
      r.end_line     = line_q;
      r.end_column   = col_q;
      r.unterminated = unterm;
      r.last         = 1'b0;
      add_expect(r);
      step_cnt++;
      segs_o++;
      if (unterm) unterm_o++;
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input bit nv, input logic [7:0] n,
                           output bit took);
    took = 1'b0;
    case (mode_q)
      ModeNormal: begin
        if (c == ChQuote) begin
          content_q = 1'b1;
          mode_q    = ModeString;
          step_pos(c);
        end else if (c == ChDash && nv && n == ChDash) begin
          mode_q = ModeLine;
          step_pos(c);
          step_pos(n);
          took = 1'b1;
        end else if (c == ChSlash && nv && n == ChStar) begin
          mode_q = ModeBlock;
          step_pos(c);
          step_pos(n);
          took = 1'b1;
        end else if (c == ChSemi) begin
          step_pos(c);
          if (content_q) emit_seg(1'b0);
          st_off_q  = off_q;
          st_line_q = line_q;
          st_col_q  = col_q;
          content_q = 1'b0;
        end else begin
          if (!(c == ChSpace || c == ChTab || c == ChLf || c == ChCr ||
                c == ChFf || c == ChVt)) content_q = 1'b1;
          step_pos(c);
        end
      end
      ModeString: begin
        if (c == ChQuote && nv && n == ChQuote) begin
          step_pos(c);
          step_pos(n);
          took = 1'b1;
        end else begin
          if (c == ChQuote) mode_q = ModeNormal;
          step_pos(c);
        end
      end
      ModeLine: begin
        step_pos(c);
        if (c == ChLf) mode_q = ModeNormal;
      end
      default: begin
        if (c == ChStar && nv && n == ChSlash) begin
          step_pos(c);
          step_pos(n);
          mode_q = ModeNormal;
          took = 1'b1;
        end else begin
          step_pos(c);
        end
      end
    endcase
  endtask

  task automatic predict_item(input logic [7:0] b, input bit eot);
    bit          pend;
    bit          paired;
    bit          unused;
    bit          unterm;
    int unsigned lim;
    int unsigned count;
    result_t     r;
    step_cnt = 0;
    paired   = 1'b0;
    pend     = held_v && !held_used;
    lim      = (limit_q > MaxTextLimit) ? MaxTextLimit : limit_q;
    if (!over_q) begin
      count = off_q + (pend ? 1 : 0) + 1;
      if (count > lim) over_q = 1'b1;
    end
    if (!over_q) begin
      if (pend) scan_byte(held_q, 1'b1, b, paired);
      held_q    = b;
      held_v    = 1'b1;
      held_used = paired;
      if (eot) begin
        if (!paired) scan_byte(b, 1'b0, 8'h00, unused);
        unterm = (mode_q == ModeString) || (mode_q == ModeBlock);
        if (content_q || unterm) emit_seg(unterm);
      end
    end
    if (eot) begin
      if (over_q || step_cnt == 0) begin
        r      = '0;
        r.last = 1'b1;
        if (over_q) begin
          r.kind         = KindErr;
          r.begin_line   = 17'd1;
          r.begin_column = 17'd1;
          r.end_line     = 17'd1;
          r.end_column   = 17'd1;
          errors_o++;
        end else begin
          r.kind = KindEnd;
          ends_o++;
        end
        add_expect(r);
      end else begin
        r      = segment_q.pop_back();
        r.last = 1'b1;
        add_expect(r);
      end
      clear_text();
    end
  endtask

  task automatic cmp(input string name, input logic [CntW-1:0] want,
                     input logic [CntW-1:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t w;
    if (segment_q.size() == 0) begin
      fail_count_o++;
      $display("%0t: result with nothing expected, expected none, actual kind %0d",
               $time, kind_i);
    end else begin
      w = segment_q.pop_front();
      cmp("kind", 17'(w.kind), 17'(kind_i));
      cmp("seg_begin", w.seg_begin, seg_begin_i);
      cmp("seg_end", w.seg_end, seg_end_i);
      cmp("begin_line", w.begin_line, begin_line_i);
      cmp("begin_column", w.begin_column, begin_column_i);
      cmp("end_line", w.end_line, end_line_i);
      cmp("end_column", w.end_column, end_column_i);
      cmp("unterminated", 17'(w.unterminated), 17'(unterminated_i));
      cmp("last_of_text", 17'(w.last), 17'(last_of_text_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      limit_q = 17'(MaxTextLimit);
      segment_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      items_o      = 0;
      segs_o       = 0;
      unterm_o     = 0;
      ends_o       = 0;
      errors_o     = 0;
    end else begin
      if (pop_i && !empty_i) check_result();
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (push_i && !full_i) begin
        items_o++;
        predict_item(text_byte_i, end_of_text_i);
      end
      pending_o = segment_q.size();
    end
  end

endmodule

FILE: bench/tb_sql_statement_splitter_top.sv
// testbench top for the sql statement splitter: stimulus, idling phases and verdict
module tb_sql_statement_splitter_top;
  import sss_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseBytes = 46;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            push      = 1'b0;
  logic [7:0]      text_byte = 8'h00;
  logic            eot       = 1'b0;
  logic            pop       = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [CntW-1:0] cfg_data  = '0;

  logic            full;
  logic            empty;
  logic            cfg_ready;
  logic [1:0]      kind;
  logic [CntW-1:0] seg_begin;
  logic [CntW-1:0] seg_end;
  logic [CntW-1:0] begin_line;
  logic [CntW-1:0] begin_column;
  logic [CntW-1:0] end_line;
  logic [CntW-1:0] end_column;
  logic            unterminated;
  logic            last_of_text;

  int fail_count;
  int pending;
  int items;
  int segs;
  int unterms;
  int ends;
  int errors;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int cycle_cnt    = 0;

  int              tx_tab  [4] = '{0, 63, 0, 13};
  int              rx_tab  [4] = '{0, 0, 63, 13};
  logic [CntW-1:0] lim_tab [8] = '{17'h10000, 17'd1, 17'd0, 17'h1ffff,
                                   17'd12, 17'd5, 17'd20, 17'h10000};
  int              len_tab [8] = '{20, 3, 3, 20, 24, 8, 20, 20};

  logic [7:0] text_q [$];

  sql_statement_splitter_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .text_byte_i      (text_byte),
    .end_of_text_i    (eot),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind),
    .seg_begin_o      (seg_begin),
    .seg_end_o        (seg_end),
    .begin_line_o     (begin_line),
    .begin_column_o   (begin_column),
    .end_line_o       (end_line),
    .end_column_o     (end_column),
    .unterminated_o   (unterminated),
    .last_of_text_o   (last_of_text),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .max_text_bytes_i (cfg_data)
  );

  sss_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .text_byte_i    (text_byte),
    .end_of_text_i  (eot),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .empty_i        (empty),
    .pop_i          (pop),
    .kind_i         (kind),
    .seg_begin_i    (seg_begin),
    .seg_end_i      (seg_end),
    .begin_line_i   (begin_line),
    .begin_column_i (begin_column),
    .end_line_i     (end_line),
    .end_column_i   (end_column),
    .unterminated_i (unterminated),
    .last_of_text_i (last_of_text),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .items_o        (items),
    .segs_o         (segs),
    .unterm_o       (unterms),
    .ends_o         (ends),
    .errors_o       (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    pop <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    case ($urandom_range(12))
      0:       c = ChQuote;
      1:       c = ChDash;
      2:       c = ChSlash;
      3:       c = ChStar;
      4:       c = ChSemi;
      5:       c = ChLf;
      6:       c = ChCr;
      7:       c = ChSpace;
      8:       c = ChTab;
      9:       c = ChFf;
      10:      c = ChVt;
      11:      c = 8'($urandom_range(255));
      default: c = 8'(8'h61 + $urandom_range(25));
    endcase
    return c;
  endfunction

  // statement-like text built from words, strings, comments and noise
  task automatic build_text(input int max_len);
    int target;
    text_q.delete();
    target = $urandom_range(max_len, 1);
    while (text_q.size() < target) begin
      case ($urandom_range(9)) inside
        0, 1: repeat ($urandom_range(4, 1)) put_byte(8'(8'h61 + $urandom_range(25)));
        2, 3: put_byte(odd_char());
        4: put_byte(ChSemi);
        5: begin
          put_byte(ChQuote);
          repeat ($urandom_range(3)) begin
            if ($urandom_range(2) == 0) begin
              put_byte(ChQuote);
              put_byte(ChQuote);
            end else begin
              put_byte(odd_char());
            end
          end
          if ($urandom_range(3) != 0) put_byte(ChQuote);
        end
        6: begin
          put_byte(ChDash);
          put_byte(ChDash);
          repeat ($urandom_range(3)) put_byte(odd_char());
          if ($urandom_range(3) != 0) put_byte(ChLf);
        end
        7: begin
          put_byte(ChSlash);
          put_byte(ChStar);
          repeat ($urandom_range(3)) put_byte(odd_char());
          if ($urandom_range(3) != 0) begin
            put_byte(ChStar);
            put_byte(ChSlash);
          end
        end
        8: put_byte(($urandom_range(1) == 0) ? ChSpace : ChLf);
        default: put_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    bit sent;
    sent = 1'b0;
    while (!sent) begin
      @(negedge clk_i);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
        push <= 1'b0;
      end else begin
        push      <= 1'b1;
        text_byte <= b;
        eot       <= last;
        do @(posedge clk_i); while (full);
        sent = 1'b1;
      end
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CntW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int              sent;
    logic [CntW-1:0] lim;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // byte extremes, blanks only, escaped quote, comments, unterminated text
    text_q = '{8'h00, 8'hff, ChSemi};
    send_text();
    text_q = '{ChSpace, ChTab, ChVt, ChFf, ChCr, ChLf};
    send_text();
    text_q = '{ChQuote, 8'h61, ChQuote, ChQuote};
    send_text();
    text_q = '{ChSlash, ChStar, ChStar, ChSlash, ChSemi, ChDash, ChDash, 8'h78, ChLf};
    send_text();
    text_q = '{ChSlash, ChStar};
    send_text();
    text_q = '{ChDash};
    send_text();
    text_q = '{8'h61, ChSemi, 8'h62};
    send_text();

    for (int p = 0; p < 8; p++) begin
      lim = (p == 6) ? 17'($urandom_range(30, 2)) : lim_tab[p];
      write_limit(lim);
      tx_idle_pct  = tx_tab[p % 4];
      rx_stall_pct = rx_tab[p % 4];
      sent = 0;
      while (sent < PhaseBytes) begin
        build_text(len_tab[p]);
        send_text();
        sent += text_q.size();
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    $display("run covered %0d items over 8 length limits from 0 to 131071, four idle patterns",
             items);
    $display("results: %0d segments (%0d unterminated), %0d empty ends, %0d length errors",
             segs, unterms, ends, errors);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
